[sv/qmb_pkg.sv]
// Package for the quadtree mass binning block: command codes, register
// indexes, shade constants and the tree-size helper functions.
// Used by the top level and the shade unit; depends on nothing.
package qmb_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    localparam logic [1:0] CFG_ORIGIN_X  = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y  = 2'd1;
    localparam logic [1:0] CFG_MASS_UNIT = 2'd2;

    localparam int SHADE_CAP  = 10;
    localparam int SHADE_FULL = 255;
    localparam int SHADE_STEP = SHADE_FULL / SHADE_CAP;

    localparam int MAX_SPLITS = 12;

    function automatic int f_num_levels(input int root_size, input int leaf_size);
        int n;
        n = 1;
        for (int k = 0; k <= MAX_SPLITS; k++) begin
            if ((root_size >> k) > leaf_size) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

    // First store index of each readable level, (4**level - 1) / 3.
    function automatic logic [12:0] f_level_base(input logic [2:0] level);
        logic [12:0] b;
        case (level)
            3'd0: b = 13'd0;
            3'd1: b = 13'd1;
            3'd2: b = 13'd5;
            3'd3: b = 13'd21;
            3'd4: b = 13'd85;
            3'd5: b = 13'd341;
            3'd6: b = 13'd1365;
            default: b = 13'd5461;
        endcase
        return b;
    endfunction

endpackage

[sv/quadtree_mass_binning_unit.sv]
// Add reads then writes the cell memory on each level reached; read waits for the shade
// unit's subtract loop; clear sweeps every stored cell. One transaction at a time: the
// next one is accepted in the same cycle as the result is presented.
// Reset: synchronous; the block first sweeps the cell memory to zero, one cell
// per cycle (341 cells by default), and accepts no transaction meanwhile.
module quadtree_mass_binning_unit #(
    parameter int ROOT_SIZE = 256,
    parameter int LEAF_SIZE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  qmb_pkg::t_cmd      i_command,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [15:0]        i_particle_mass,
    input  logic [2:0]         i_cell_level,
    input  logic [3:0]         i_cell_col,
    input  logic [3:0]         i_cell_row,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_cell_mass,
    output logic [7:0]         o_shade,
    output logic [2:0]         o_levels_reached,
    output logic               o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import qmb_pkg::*;

    localparam int NUM_LEVELS = f_num_levels(ROOT_SIZE, LEAF_SIZE);
    localparam int DEPTH      = ((4 ** NUM_LEVELS) - 1) / 3;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW         = (AW > 16) ? AW : 16;
    localparam int LW         = ($clog2(NUM_LEVELS + 1) > 3) ? $clog2(NUM_LEVELS + 1) : 3;
    localparam int CRW        = (NUM_LEVELS > 1) ? NUM_LEVELS - 1 : 1;
    localparam int WW         = $clog2(ROOT_SIZE) + 1;
    localparam int CW         = $clog2(ROOT_SIZE) + 18;

    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [LW-1:0] LAST_LEVEL = LW'(NUM_LEVELS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLR,
        ST_A_RD,
        ST_A_WR,
        ST_R_MEM,
        ST_R_DIV,
        ST_R_WAIT,
        ST_EMIT
    } t_state;

    t_state               r_state;
    logic                 r_emit;
    logic signed [15:0]   r_origin_x;
    logic signed [15:0]   r_origin_y;
    logic [15:0]          r_mass_unit;
    logic [AW-1:0]        r_addr;
    logic [AW-1:0]        r_base;
    logic [LW-1:0]        r_level;
    logic [CRW-1:0]       r_col;
    logic [CRW-1:0]       r_row;
    logic signed [CW-1:0] r_x0;
    logic signed [CW-1:0] r_y0;
    logic [WW-1:0]        r_w;
    logic signed [15:0]   r_px;
    logic signed [15:0]   r_py;
    logic [15:0]          r_m;
    logic [31:0]          r_res_mass;
    logic [7:0]           r_res_shade;
    logic [LW-1:0]        r_res_levels;
    logic                 r_res_status;
    logic                 r_out_valid;
    logic [31:0]          r_out_mass;
    logic [7:0]           r_out_shade;
    logic [2:0]           r_out_levels;
    logic                 r_out_status;

    logic                 ram_we;
    logic [31:0]          ram_wdata;
    logic [31:0]          ram_rdata;
    logic                 div_start;
    logic                 div_done;
    logic [7:0]           div_shade;

    logic                 in_accept;
    logic                 out_free;
    logic [32:0]          sum;
    logic [31:0]          sat;
    logic signed [CW-1:0] px_e;
    logic signed [CW-1:0] py_e;
    logic signed [CW-1:0] w_s;
    logic signed [CW-1:0] half_s;
    logic                 in_cell;
    logic                 right;
    logic                 bottom;
    logic [LW-1:0]        n_level;
    logic [CRW-1:0]       n_col;
    logic [CRW-1:0]       n_row;
    logic [AW-1:0]        n_base;
    logic [AW-1:0]        n_idx;
    logic [IW-1:0]        rd_idx;
    logic                 rd_bad;

    assign in_accept   = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign sum = {1'b0, ram_rdata} + {17'd0, r_m};
    assign sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    assign px_e    = CW'(r_px);
    assign py_e    = CW'(r_py);
    assign w_s     = CW'($signed({1'b0, r_w}));
    assign half_s  = CW'($signed({1'b0, r_w >> 1}));
    assign in_cell = (px_e >= r_x0) && (px_e <= r_x0 + w_s) &&
                     (py_e >= r_y0) && (py_e <= r_y0 + w_s);
    assign right   = px_e > r_x0 + half_s;
    assign bottom  = py_e > r_y0 + half_s;

    assign n_level = r_level + LW'(1);
    assign n_col   = {r_col[CRW-2 >= 0 ? CRW-2 : 0:0], right} & {CRW{1'b1}};
    assign n_row   = {r_row[CRW-2 >= 0 ? CRW-2 : 0:0], bottom} & {CRW{1'b1}};
    assign n_base  = {r_base[AW-3 >= 0 ? AW-3 : 0:0], 2'b01} & {AW{1'b1}};
    assign n_idx   = n_base + (AW'(n_row) << n_level) + AW'(n_col);

    assign rd_idx = IW'(f_level_base(i_cell_level)) + (IW'(i_cell_row) << i_cell_level) +
                    IW'(i_cell_col);
    assign rd_bad = ({29'd0, i_cell_level} >= 32'(NUM_LEVELS)) ||
                    ((i_cell_col >> i_cell_level) != 4'd0) ||
                    ((i_cell_row >> i_cell_level) != 4'd0);

    assign ram_we    = (r_state == ST_CLR) || (r_state == ST_A_WR);
    assign ram_wdata = (r_state == ST_CLR) ? 32'd0 : sat;
    assign div_start = (r_state == ST_R_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_mass_unit <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:  r_origin_x  <= i_cfg_data;
                CFG_ORIGIN_Y:  r_origin_y  <= i_cfg_data;
                CFG_MASS_UNIT: r_mass_unit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_emit      <= 1'b0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_res_mass   <= '0;
                        r_res_shade  <= '0;
                        r_res_levels <= '0;
                        r_res_status <= 1'b0;
                        unique case (i_command)
                            CMD_ADD: begin
                                r_px    <= i_pos_x;
                                r_py    <= i_pos_y;
                                r_m     <= i_particle_mass;
                                r_x0    <= CW'(r_origin_x);
                                r_y0    <= CW'(r_origin_y);
                                r_w     <= WW'(ROOT_SIZE);
                                r_level <= '0;
                                r_col   <= '0;
                                r_row   <= '0;
                                r_base  <= '0;
                                r_addr  <= '0;
                                r_state <= ST_A_RD;
                            end
                            CMD_CLEAR: begin
                                r_addr  <= '0;
                                r_emit  <= 1'b1;
                                r_state <= ST_CLR;
                            end
                            CMD_READ: begin
                                if (rd_bad) begin
                                    r_res_status <= 1'b1;
                                    r_state      <= ST_EMIT;
                                end else begin
                                    r_addr  <= rd_idx[AW-1:0];
                                    r_state <= ST_R_MEM;
                                end
                            end
                            default: r_state <= ST_EMIT;
                        endcase
                    end
                end
                ST_CLR: begin
                    if (r_addr == LAST_ADDR) begin
                        r_state <= r_emit ? ST_EMIT : ST_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                ST_A_RD: r_state <= ST_A_WR;
                ST_A_WR: begin
                    r_res_levels <= n_level;
                    if ((r_level != LAST_LEVEL) && in_cell) begin
                        if (right) begin
                            r_x0 <= r_x0 + half_s;
                        end
                        if (bottom) begin
                            r_y0 <= r_y0 + half_s;
                        end
                        r_w     <= r_w >> 1;
                        r_level <= n_level;
                        r_col   <= n_col;
                        r_row   <= n_row;
                        r_base  <= n_base;
                        r_addr  <= n_idx;
                        r_state <= ST_A_RD;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_R_MEM: r_state <= ST_R_DIV;
                ST_R_DIV: begin
                    r_res_mass <= ram_rdata;
                    r_state    <= ST_R_WAIT;
                end
                ST_R_WAIT: begin
                    if (div_done) begin
                        r_res_shade <= div_shade;
                        r_state     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_mass   <= r_res_mass;
                        r_out_shade  <= r_res_shade;
                        r_out_levels <= r_res_levels[2:0];
                        r_out_status <= r_res_status;
                        r_emit       <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    qmb_cell_ram #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_cell_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_addr),
        .i_wdata(ram_wdata),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    qmb_shade_unit u_shade_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_mass (ram_rdata),
        .i_unit (r_mass_unit),
        .o_done (div_done),
        .o_shade(div_shade)
    );

    assign o_valid          = r_out_valid;
    assign o_cell_mass      = r_out_mass;
    assign o_shade          = r_out_shade;
    assign o_levels_reached = r_out_levels;
    assign o_status         = r_out_status;

endmodule

[sv/qmb_cell_ram.sv]
// Cell mass memory with one write port and one registered read port.
// Depends on nothing; depth and address width come from the top level.
module qmb_cell_ram #(
    parameter int DEPTH = 341,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/qmb_shade_unit.sv]
// Iterative shade unit: repeated compare and subtract of the mass unit,
// capped at ten steps, gives min(10, mass / unit) * 25.
// Depends on qmb_pkg for the shade constants.
module qmb_shade_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_mass,
    input  logic [15:0] i_unit,
    output logic        o_done,
    output logic [7:0]  o_shade
);
    import qmb_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    localparam logic [3:0] CAP  = 4'(SHADE_CAP);
    localparam logic [7:0] STEP = 8'(SHADE_STEP);

    t_state      r_state;
    logic [31:0] r_rem;
    logic [15:0] r_unit;
    logic [3:0]  r_q;
    logic [7:0]  r_shade;
    logic        r_done;

    logic        stop;

    assign stop = (r_q == CAP) || (r_rem < {16'd0, r_unit});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_rem   <= i_mass;
                        r_unit  <= (i_unit == 16'd0) ? 16'd1 : i_unit;
                        r_q     <= 4'd0;
                        r_shade <= 8'd0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (stop) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_rem   <= r_rem - {16'd0, r_unit};
                        r_q     <= r_q + 4'd1;
                        r_shade <= r_shade + STEP;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_shade = r_shade;

endmodule
